>>> rtl/ecqs_pkg.sv
`default_nettype none
package ecqs_pkg;

   localparam int MAX_SAMPLES   = 1024;
   localparam int MAX_QUANTILES = 64;
   localparam int SAMPLE_WIDTH  = 32;

   localparam int ADDR_W  = $clog2(MAX_SAMPLES);
   localparam int COUNT_W = ADDR_W + 1;
   localparam int NQ_W    = 7;
   localparam int IDX_W   = 6;
   localparam int DIFF_W  = SAMPLE_WIDTH + 1;
   localparam int PROD_W  = DIFF_W + NQ_W;
   localparam int DIV_W   = PROD_W;
   localparam int DCNT_W  = $clog2(DIV_W);

   localparam logic CSR_QUANTILE_COUNT  = 1'b0;
   localparam logic CSR_DEFINITION_MODE = 1'b1;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ADV,
      ST_RD_LO,
      ST_RD_HI,
      ST_CALC,
      ST_MUL,
      ST_IDIV_START,
      ST_IDIV_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_SEL,
      OP_AVG,
      OP_INTERP
   } cut_op_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [NQ_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [NQ_W-1:0]   remainder;
   } div_rsp_type;

endpackage
`default_nettype wire

>>> rtl/ecqs_divider.sv
`default_nettype none
module ecqs_divider
   import ecqs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [NQ_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [NQ_W-1:0]   dvs_ff, dvs_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NQ_W:0]     shifted;
   logic              ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         cnt_in  = '0;
         dvs_in  = div_req.divisor;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? NQ_W'(shifted - {1'b0, dvs_ff}) : shifted[NQ_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done longer than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("divider done without work");
`endif

endmodule
`default_nettype wire

>>> rtl/equal_count_quantiles_sorted.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall    | sample_value, last_sample
// rsp     | out       | rsp_valid/stall    | quantile_value, index, final, dropped
// csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// Samples load at one per cycle while req_stall is low, into a sample memory
// with one write and one read port. After the last sample the step division
// runs; per cut point: advance, read low, read high (registered), calculate,
// multiply and remainder division when interpolating, wait for rsp accept.
// Reset is synchronous; the sample memory is not cleared.
// req_stall is high for the whole result phase; rsp_stall holds the result.
`default_nettype none
module equal_count_quantiles_sorted
   import ecqs_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample_value,
   input  wire logic                           req_last_sample,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_quantile_value,
   output logic [IDX_W-1:0]                    rsp_quantile_index,
   output logic                                rsp_final_result,
   output logic                                rsp_samples_dropped,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [NQ_W-1:0]                csr_data
);

   logic [SAMPLE_WIDTH-1:0] mem [MAX_SAMPLES];
   logic [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    mem_we;

   state_type state_ff, state_in;

   logic [NQ_W-1:0]    qcount_ff;
   logic               mode_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               ovf_ff;
   logic [NQ_W-1:0]    nq;
   logic [COUNT_W-1:0] step;

   logic [COUNT_W-1:0] qs_ff, q_ff;
   logic [NQ_W-1:0]    rs_ff, r_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               final_pt;
   logic [NQ_W:0]      r_sum;

   cut_op_type        op_ff, op_c;
   logic [ADDR_W-1:0] lo_addr, hi_addr, hi_addr_ff;
   logic signed [SAMPLE_WIDTH-1:0] lo_ff, hi_ff, val_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] avg_sum;
   logic [DIV_W-1:0]  adj;
   logic signed [DIFF_W-1:0] interp;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic req_acc, rsp_acc, calc_done;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (qcount_ff == '0) begin
         nq = NQ_W'(1);
      end else if (qcount_ff > NQ_W'(MAX_QUANTILES)) begin
         nq = NQ_W'(MAX_QUANTILES);
      end else begin
         nq = qcount_ff;
      end
   end

   assign step     = mode_ff ? count_ff + 1'b1 : count_ff;
   assign final_pt = ({1'b0, idx_ff} + 1'b1) == nq;
   assign r_sum    = {1'b0, r_ff} + {1'b0, rs_ff};

   // where the current cut point reads, and how it combines the two samples
   always_comb begin
      op_c    = OP_SEL;
      lo_addr = q_ff[ADDR_W-1:0];
      hi_addr = q_ff[ADDR_W-1:0];
      if (final_pt) begin
         lo_addr = ADDR_W'(count_ff - 1'b1);
         hi_addr = lo_addr;
      end else if (!mode_ff) begin
         if (r_ff == '0) begin
            op_c    = OP_AVG;
            lo_addr = ADDR_W'(q_ff - 1'b1);
         end
      end else if (q_ff == '0) begin
         lo_addr = '0;
         hi_addr = '0;
      end else if (q_ff >= count_ff) begin
         lo_addr = ADDR_W'(count_ff - 1'b1);
         hi_addr = lo_addr;
      end else begin
         op_c    = OP_INTERP;
         lo_addr = ADDR_W'(q_ff - 1'b1);
      end
   end

   assign calc_done = (op_ff != OP_INTERP);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:       if (req_acc && req_last_sample) state_in = ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:   if (div_rsp.done) state_in = ST_ADV;
         ST_ADV:        state_in = ST_RD_LO;
         ST_RD_LO:      state_in = ST_RD_HI;
         ST_RD_HI:      state_in = ST_CALC;
         ST_CALC:       state_in = calc_done ? ST_OUT : ST_MUL;
         ST_MUL:        state_in = ST_IDIV_START;
         ST_IDIV_START: state_in = ST_IDIV_WAIT;
         ST_IDIV_WAIT:  if (div_rsp.done) state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_acc) state_in = rsp_final_result ? ST_LOAD : ST_ADV;
         end
         default:       state_in = ST_LOAD;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall        = (state_ff != ST_LOAD);
      rsp_valid        = (state_ff == ST_OUT);
      mem_we           = req_acc && (count_ff < COUNT_W'(MAX_SAMPLES));
      rd_addr          = (state_ff == ST_RD_LO) ? lo_addr : hi_addr_ff;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(step);
      div_req.divisor  = nq;
      case (state_ff)
         ST_DIV_START:  div_req.start = 1'b1;
         ST_IDIV_START: begin
            div_req.start = 1'b1;
            // floor of a negative quotient through the magnitude rounded up
            div_req.dividend = prod_ff[PROD_W-1] ?
               DIV_W'(-prod_ff) + DIV_W'(nq - 1'b1) : DIV_W'(prod_ff);
         end
         default: ;
      endcase
   end

   assign diff    = DIFF_W'(hi_ff) - DIFF_W'(lo_ff);
   assign avg_sum = DIFF_W'(lo_ff) + DIFF_W'($signed(rd_data_ff));
   assign adj     = prod_ff[PROD_W-1] ? -div_rsp.quotient : div_rsp.quotient;
   assign interp  = DIFF_W'(lo_ff) + $signed(adj[DIFF_W-1:0]);

   always_ff @(posedge clock) begin
      if (mem_we) mem[count_ff[ADDR_W-1:0]] <= req_sample_value;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         qcount_ff <= NQ_W'(4);
         mode_ff   <= 1'b0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_QUANTILE_COUNT:  qcount_ff <= csr_data;
               CSR_DEFINITION_MODE: mode_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (req_acc) begin
            if (mem_we) count_ff <= count_ff + 1'b1;
            else        ovf_ff   <= 1'b1;
         end
         if (rsp_acc && rsp_final_result) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DIV_START: begin
            q_ff   <= '0;
            r_ff   <= '0;
            idx_ff <= '0;
         end
         ST_DIV_WAIT: begin
            qs_ff <= div_rsp.quotient[COUNT_W-1:0];
            rs_ff <= div_rsp.remainder;
         end
         ST_ADV: begin
            if (r_sum >= {1'b0, nq}) begin
               r_ff <= NQ_W'(r_sum - {1'b0, nq});
               q_ff <= q_ff + qs_ff + 1'b1;
            end else begin
               r_ff <= r_sum[NQ_W-1:0];
               q_ff <= q_ff + qs_ff;
            end
         end
         ST_RD_LO: begin
            op_ff      <= op_c;
            hi_addr_ff <= hi_addr;
         end
         ST_RD_HI: lo_ff <= $signed(rd_data_ff);
         ST_CALC: begin
            hi_ff <= $signed(rd_data_ff);
            if (op_ff == OP_AVG) val_ff <= avg_sum[DIFF_W-1:1];
            else                 val_ff <= $signed(rd_data_ff);
         end
         ST_MUL: prod_ff <= diff * $signed({1'b0, r_ff});
         ST_IDIV_WAIT: val_ff <= interp[SAMPLE_WIDTH-1:0];
         ST_OUT: if (rsp_acc) idx_ff <= idx_ff + 1'b1;
         default: ;
      endcase
   end

   assign rsp_quantile_value  = val_ff;
   assign rsp_quantile_index  = idx_ff;
   assign rsp_final_result    = final_pt;
   assign rsp_samples_dropped = ovf_ff;

   ecqs_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

`ifndef SYNTH
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SAMPLES)) else $error("sample count beyond capacity");
   a_write_in_load: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_LOAD) else $error("sample write outside load");
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_final_result |=> count_ff == '0 && !ovf_ff)
      else $error("run state not cleared");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_quantile_index} < nq) else $error("index past count");
`endif

endmodule
`default_nettype wire
